/* src/stereo_flanger_delay_line_top_macros.svh */
// Assertion macros used by the stereo flanger checker
`ifndef STEREO_FLANGER_DELAY_LINE_TOP_MACROS_SVH
`define STEREO_FLANGER_DELAY_LINE_TOP_MACROS_SVH
// Assert that an antecedent implies a consequent in the next cycle
`define SFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Assert that an expression holds at every edge out of reset
`define SFL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`endif

/* src/sfl_pkg.sv */
// Shared types, constants and sine table for the stereo flanger
`timescale 1ns / 1ps
package sfl_pkg;
  localparam int unsigned BufDepth   = 1024;
  localparam int unsigned AddrW      = 10;
  localparam int unsigned SineDepth  = 1024;
  localparam int unsigned SineAw     = 10;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned SampleW    = 24;

  localparam logic [CfgIdxW-1:0] RegCenter   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSwing    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDepth    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidth    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegStep     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFeedback = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDamping  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegLength   = 3'd7;

  // Operation codes sequenced by the controller
  typedef enum logic [3:0] {
    OpIdle, OpLoad, OpModA, OpModB, OpModR, OpDelay, OpAddrL, OpAddrR,
    OpRdL, OpRdR, OpFbL, OpFbR, OpWr, OpOut
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } ctl_t;

  typedef struct packed {
    logic out_busy;
    logic init;
  } sts_t;

  // sin(2*pi*k/SineDepth) in Q1.15, quarter-wave Taylor series in Q30
  function automatic logic signed [16:0] sine_entry(input logic [SineAw-1:0] k);
    logic [63:0] u, quad, r, x, x2, t, s;
    u = ({54'd0, k} << 32) / SineDepth;
    quad = (u >> 30) & 64'd3;
    r = u & 64'h3FFF_FFFF;
    if (quad[0]) r = 64'h4000_0000 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = 64'h4000_0000 - x2 / 110;
    t = 64'h4000_0000 - ((x2 * t) >> 30) / 72;
    t = 64'h4000_0000 - ((x2 * t) >> 30) / 42;
    t = 64'h4000_0000 - ((x2 * t) >> 30) / 20;
    t = 64'h4000_0000 - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return quad[1] ? -$signed({1'b0, s[15:0]}) : $signed({1'b0, s[15:0]});
  endfunction

  // First quarter of the wave, built at elaboration
  typedef logic [255:0][15:0] sine_tab_t;

  function automatic sine_tab_t sine_quarter();
    sine_tab_t tab;
    logic signed [16:0] e;
    for (int k = 0; k < 256; k++) begin
      e = sine_entry(SineAw'(k));
      tab[k] = e[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SineQuarter = sine_quarter();
  localparam logic signed [16:0] SinePeak = sine_entry(SineAw'(256));

  // Full-wave lookup by quarter symmetry; the quarter point has its own entry
  function automatic logic signed [16:0] sine_lookup(input logic [SineAw-1:0] k);
    logic [8:0] m;
    logic [15:0] mag;
    m = k[8] ? 9'd256 - {1'b0, k[7:0]} : {1'b0, k[7:0]};
    mag = m[8] ? SinePeak[15:0] : SineQuarter[m[7:0]];
    return k[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction
endpackage

/* src/sfl_stream_if.sv */
// Valid/ready stream channel with a generic payload
`timescale 1ns / 1ps
interface sfl_stream_if #(parameter int unsigned W = 24);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/stereo_flanger_delay_line_top.sv */
// Stereo flanger top level: mono in, stereo pair out
//
// Usage: one mono Q1.23 sample enters on in_ch; one left/right pair leaves
// on out_ch. Both channels are valid/ready; a request moves when both are
// high at a rising clk_i edge. Registers are to be written over cfg_we_i,
// cfg_idx_i and cfg_data_i only while the block is idle; the block itself
// does not enforce this. A sample passes through the controller's
// thirteen-step sequence from acceptance to a valid result; the next sample
// is taken the cycle after the result is loaded. The products are spread
// over the steps, with two reads of each store in a single step.
// Reset (rst_ni low) restores register defaults, the write position and the
// LFO phase. After reset a clearing pass zeroes all 1024 entries of both
// stores; no sample is accepted until it ends.
// If the receiver stalls, the result register holds; the next sample is
// still accepted and runs up to its store write, then waits until the held
// result is taken.
`timescale 1ns / 1ps
module stereo_flanger_delay_line_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sfl_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sfl_pkg::CfgDataW-1:0]    cfg_data_i,
  sfl_stream_if.sink                      in_ch,
  sfl_stream_if.source                    out_ch
);
  sfl_pkg::ctl_t ctl;
  sfl_pkg::sts_t sts;
  logic ctrl_ready;
  logic signed [23:0] left, right;

  sfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid && !sts.init),
    .in_ready_o (ctrl_ready),
    .out_busy_i (sts.out_busy),
    .ctl_o      (ctl)
  );

  sfl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .sample_i    (in_ch.data[23:0]),
    .sts_o       (sts),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .left_o      (left),
    .right_o     (right)
  );

  assign in_ch.ready = ctrl_ready && !sts.init;
  assign out_ch.data = {right, left};
endmodule

/* src/sfl_ctrl.sv */
// Controller state machine stepping the datapath through one request
`timescale 1ns / 1ps
module sfl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  output sfl_pkg::ctl_t  ctl_o
);
  sfl_pkg::op_e op_q, op_d;

  always_comb begin
    op_d = op_q;
    unique case (op_q)
      sfl_pkg::OpIdle:  if (in_valid_i) op_d = sfl_pkg::OpLoad;
      sfl_pkg::OpLoad:  op_d = sfl_pkg::OpModA;
      sfl_pkg::OpModA:  op_d = sfl_pkg::OpModB;
      sfl_pkg::OpModB:  op_d = sfl_pkg::OpModR;
      sfl_pkg::OpModR:  op_d = sfl_pkg::OpDelay;
      sfl_pkg::OpDelay: op_d = sfl_pkg::OpAddrL;
      sfl_pkg::OpAddrL: op_d = sfl_pkg::OpAddrR;
      sfl_pkg::OpAddrR: op_d = sfl_pkg::OpRdL;
      sfl_pkg::OpRdL:   op_d = sfl_pkg::OpRdR;
      sfl_pkg::OpRdR:   op_d = sfl_pkg::OpFbL;
      sfl_pkg::OpFbL:   op_d = sfl_pkg::OpFbR;
      sfl_pkg::OpFbR:   op_d = sfl_pkg::OpWr;
      sfl_pkg::OpWr:    if (!out_busy_i) op_d = sfl_pkg::OpOut;
      sfl_pkg::OpOut:   op_d = sfl_pkg::OpIdle;
      default:          op_d = sfl_pkg::OpIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= sfl_pkg::OpIdle;
    end else begin
      op_q <= op_d;
    end
  end

  assign in_ready_o = (op_q == sfl_pkg::OpIdle);
  assign ctl_o.start = in_ready_o && in_valid_i;
  assign ctl_o.op = op_q;
endmodule

/* src/sfl_datapath.sv */
// Flanger datapath: config registers, LFO, delay stores, shared math
`timescale 1ns / 1ps
module sfl_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sfl_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sfl_pkg::CfgDataW-1:0]      cfg_data_i,
  input  sfl_pkg::ctl_t                     ctl_i,
  input  logic signed [sfl_pkg::SampleW-1:0] sample_i,
  output sfl_pkg::sts_t                     sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [sfl_pkg::SampleW-1:0] left_o,
  output logic signed [sfl_pkg::SampleW-1:0] right_o
);
  localparam logic signed [23:0] SMax = 24'sh7FFFFF;
  localparam logic signed [23:0] SMin = -24'sh800000;

  logic [17:0] center_q, swing_q;
  logic [15:0] depth_q, width_q, damping_q;
  logic [31:0] step_q, phase_q;
  logic [14:0] fb_q;
  logic [10:0] blen_q, len_q;
  logic [sfl_pkg::AddrW-1:0] widx_q, w_q;
  logic [sfl_pkg::AddrW:0] clr_q;

  logic signed [23:0] x_q;
  logic signed [16:0] sine_q;
  logic signed [47:0] prod_q;
  logic signed [31:0] modl_q;
  logic signed [31:0] dl_q, dr_q;
  logic [sfl_pkg::AddrW-1:0] i0_q, i1_q, j0_q, j1_q;
  logic [7:0] fl_q, fr_q;
  logic signed [23:0] a_q, b_q, dlyl_q, dlyr_q;
  logic signed [23:0] wl_q, wr_q, outl_q, outr_q;
  logic out_v_q;

  logic signed [23:0] lmem [sfl_pkg::BufDepth];
  logic signed [23:0] rmem [sfl_pkg::BufDepth];

  function automatic logic signed [23:0] sat(input logic signed [47:0] v);
    if (v > 48'sh7FFFFF) return SMax;
    if (v < -48'sh800000) return SMin;
    return v[23:0];
  endfunction

  // floor((v + 2^(n-1)) / 2^n)
  function automatic logic signed [47:0] rnd(input logic signed [63:0] v, input int n);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (n - 1))) >>> n;
    return t[47:0];
  endfunction

  function automatic logic signed [31:0] clampd(input logic signed [31:0] d,
                                                 input logic [10:0] len);
    logic signed [31:0] hi, r;
    hi = $signed({13'd0, len - 11'd1, 8'd0});
    r = (d > hi) ? hi : d;
    if (r < 32'sd256) r = 32'sd256;
    return r;
  endfunction

  // Read position in Q8 with wrap into the active length
  function automatic logic [18:0] rpos(input logic [sfl_pkg::AddrW-1:0] w,
                                       input logic [10:0] len,
                                       input logic signed [31:0] d);
    logic signed [31:0] p;
    p = $signed({14'd0, w, 8'd0}) - d;
    if (p < 0) p = p + $signed({13'd0, len, 8'd0});
    return p[18:0];
  endfunction

  logic [10:0] lenc;
  logic [18:0] pl, pr;
  logic [10:0] nl0, nr0;
  logic clearing;
  logic signed [63:0] mx;

  assign clearing = !clr_q[sfl_pkg::AddrW];
  assign lenc = (blen_q < 11'd2) ? 11'd2 : (blen_q > 11'd1024) ? 11'd1024 : blen_q;
  assign pl = rpos(w_q, len_q, dl_q);
  assign pr = rpos(w_q, len_q, dr_q);
  assign nl0 = ({1'b0, pl[17:8]} >= len_q) ? 11'd0 : {1'b0, pl[17:8]};
  assign nr0 = ({1'b0, pr[17:8]} >= len_q) ? 11'd0 : {1'b0, pr[17:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= 18'd31046; swing_q <= 18'd25402; depth_q <= 16'd32768;
      width_q <= 16'd19661; step_q <= 32'd48696; fb_q <= 15'd22938;
      damping_q <= 16'd32768; blen_q <= 11'd222;
      phase_q <= '0; widx_q <= '0; clr_q <= '0; out_v_q <= 1'b0;
    end else begin
      if (clearing) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sfl_pkg::RegCenter:   center_q <= cfg_data_i[17:0];
          sfl_pkg::RegSwing:    swing_q <= cfg_data_i[17:0];
          sfl_pkg::RegDepth:    depth_q <= cfg_data_i[15:0];
          sfl_pkg::RegWidth:    width_q <= cfg_data_i[15:0];
          sfl_pkg::RegStep:     step_q <= cfg_data_i;
          sfl_pkg::RegFeedback: fb_q <= cfg_data_i[14:0];
          sfl_pkg::RegDamping:  damping_q <= cfg_data_i[15:0];
          sfl_pkg::RegLength:   blen_q <= cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (ctl_i.op == sfl_pkg::OpLoad) phase_q <= phase_q + step_q;
      if (ctl_i.op == sfl_pkg::OpWr) begin
        widx_q <= ({1'b0, w_q} + 11'd1 >= len_q) ? '0 : w_q + 1'b1;
      end
      if (ctl_i.op == sfl_pkg::OpOut) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
    end
  end

  // Payload registers and the shared multiply
  always_comb begin
    mx = '0;
    unique case (ctl_i.op)
      sfl_pkg::OpModA: mx = 64'(sine_q) * $signed({1'b0, swing_q});
      sfl_pkg::OpModB: mx = 64'(prod_q) * $signed({1'b0, depth_q});
      sfl_pkg::OpModR: mx = 64'(modl_q) * $signed({1'b0, width_q});
      sfl_pkg::OpRdR:  mx = 64'(dlyl_q) * $signed({1'b0, fb_q});
      sfl_pkg::OpFbL:  mx = 64'(prod_q) * $signed({1'b0, damping_q});
      sfl_pkg::OpFbR:  mx = 64'(prod_q) * $signed({1'b0, damping_q});
      default: mx = '0;
    endcase
  end

  logic signed [23:0] interp;
  logic [7:0] fsel;
  assign fsel = (ctl_i.op == sfl_pkg::OpRdL) ? fl_q : fr_q;
  assign interp = 24'(rnd(64'(a_q) * 256 + (64'(b_q) - 64'(a_q)) * $signed({1'b0, fsel}), 8));

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.op)
      sfl_pkg::OpIdle: if (ctl_i.start) x_q <= sample_i;
      sfl_pkg::OpLoad: begin
        sine_q <= sfl_pkg::sine_lookup(phase_q[31 -: sfl_pkg::SineAw]);
        len_q <= lenc;
        w_q <= ({1'b0, widx_q} >= lenc) ? '0 : widx_q;
      end
      sfl_pkg::OpModA: prod_q <= mx[47:0];
      sfl_pkg::OpModB: modl_q <= 32'(rnd(mx, 30));
      sfl_pkg::OpModR: begin
        dl_q <= $signed({14'd0, center_q}) + modl_q;
        dr_q <= $signed({14'd0, center_q}) - 32'(rnd(mx, 15));
      end
      sfl_pkg::OpDelay: begin
        dl_q <= clampd(dl_q, len_q);
        dr_q <= clampd(dr_q, len_q);
      end
      sfl_pkg::OpAddrL: begin
        i0_q <= nl0[9:0];
        i1_q <= (nl0 + 11'd1 >= len_q) ? '0 : 10'(nl0 + 11'd1);
        fl_q <= pl[7:0];
        j0_q <= nr0[9:0];
        j1_q <= (nr0 + 11'd1 >= len_q) ? '0 : 10'(nr0 + 11'd1);
        fr_q <= pr[7:0];
      end
      sfl_pkg::OpAddrR: begin
        a_q <= lmem[i0_q];
        b_q <= lmem[i1_q];
      end
      sfl_pkg::OpRdL: begin
        dlyl_q <= interp;
        a_q <= rmem[j0_q];
        b_q <= rmem[j1_q];
      end
      sfl_pkg::OpRdR: begin
        dlyr_q <= interp;
        prod_q <= mx[47:0];
      end
      sfl_pkg::OpFbL: begin
        wl_q <= sat(48'(x_q) + rnd(mx, 30));
        prod_q <= 48'(64'(dlyr_q) * $signed({1'b0, fb_q}));
      end
      sfl_pkg::OpFbR: begin
        wr_q <= sat(48'(x_q) + rnd(mx, 30));
        outl_q <= sat(48'(x_q) + rnd(64'(dlyl_q) * $signed({1'b0, depth_q}), 15));
        outr_q <= sat(48'(x_q) + rnd(64'(dlyr_q) * $signed({1'b0, depth_q}), 15));
      end
      default: ;
    endcase
    if (clearing) begin
      lmem[clr_q[sfl_pkg::AddrW-1:0]] <= '0;
      rmem[clr_q[sfl_pkg::AddrW-1:0]] <= '0;
    end else if (ctl_i.op == sfl_pkg::OpWr) begin
      lmem[w_q] <= wl_q;
      rmem[w_q] <= wr_q;
    end
    if (ctl_i.op == sfl_pkg::OpOut) begin
      left_o <= outl_q;
      right_o <= outr_q;
    end
  end

  assign sts_o.out_busy = out_v_q;
  assign sts_o.init = clearing;
  assign out_valid_o = out_v_q;
endmodule

/* src/sfl_checker.sv */
// Port-level checker for the stereo flanger, bound to the top level
`timescale 1ns / 1ps
`include "stereo_flanger_delay_line_top_macros.svh"
module sfl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [47:0] out_data_i
);
  logic in_acc, out_stall;

  assign in_acc = in_valid_i && in_ready_i && !out_valid_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // Handshake outputs are always driven out of reset
  `SFL_ASSERT_ALWAYS(a_known, clk_i, rst_ni, !$isunknown({in_ready_i, out_valid_i}), "X on handshake")
  // With no result pending, a request yields no result in the next cycle
  `SFL_ASSERT_NEXT(a_latency, clk_i, rst_ni, in_acc, !out_valid_i, "result too early")
  // A stalled result stays valid
  `SFL_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, out_stall, out_valid_i, "stalled result dropped")
  // A stalled result holds its data
  `SFL_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_stall, $stable(out_data_i), "stalled result changed")
endmodule

bind stereo_flanger_delay_line_top sfl_checker u_sfl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_data_i  (out_ch.data)
);
